// ----- rtl/rfe_pkg.sv -----
// Shared types and constants for the Euler-angle rotation matrix block.
`default_nettype none

package rfe_pkg;

  localparam int unsigned AngleW       = 16;
  localparam int unsigned PhaseW       = 32;
  localparam int unsigned FoldW        = 34;
  localparam int unsigned TrigW        = 22;
  localparam int unsigned ProdW        = 44;
  localparam int unsigned ElemW        = 16;
  localparam int unsigned CordicSteps  = 16;
  localparam int unsigned MatrixStages = 3;
  localparam int unsigned PipeStages   = CordicSteps + 1 + MatrixStages;

  localparam logic signed [FoldW-1:0]  PhaseHalfPi = 34'sd1686629713;
  localparam logic signed [FoldW-1:0]  PhasePi     = 34'sd3373259426;
  localparam logic signed [PhaseW-1:0] CordicX0    = 32'sd652032874;

  localparam logic signed [PhaseW-1:0] AtanTab [CordicSteps] = '{
    32'sd843314857, 32'sd497837829, 32'sd263043837, 32'sd133525159,
    32'sd67021687,  32'sd33543516,  32'sd16775851,  32'sd8388437,
    32'sd4194283,   32'sd2097149,   32'sd1048576,   32'sd524288,
    32'sd262144,    32'sd131072,    32'sd65536,     32'sd32768
  };

  typedef struct packed {
    logic signed [PhaseW-1:0] phase;
    logic                     neg;
  } angle_t;

  typedef struct packed {
    angle_t alpha;
    angle_t beta;
    angle_t gamma;
  } item_t;

  typedef struct packed {
    logic signed [TrigW-1:0] sa;
    logic signed [TrigW-1:0] ca;
    logic signed [TrigW-1:0] sb;
    logic signed [TrigW-1:0] cb;
    logic signed [TrigW-1:0] sg;
    logic signed [TrigW-1:0] cg;
  } trig_t;

  typedef struct packed {
    logic [ElemW-1:0] r1c1;
    logic [ElemW-1:0] r2c1;
    logic [ElemW-1:0] r3c1;
    logic [ElemW-1:0] r1c2;
    logic [ElemW-1:0] r2c2;
    logic [ElemW-1:0] r3c2;
    logic [ElemW-1:0] r1c3;
    logic [ElemW-1:0] r2c3;
    logic [ElemW-1:0] r3c3;
  } matrix_t;

endpackage

`default_nettype wire

// ----- rtl/rfe_front.sv -----
// Front end: folds each angle into the CORDIC range and queues the transaction.
`default_nettype none

module rfe_front import rfe_pkg::*; #(
  parameter int unsigned QueueDepth = 4
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  logic [AngleW-1:0] angle_alpha_i,
  input  logic [AngleW-1:0] angle_beta_i,
  input  logic [AngleW-1:0] angle_gamma_i,
  input  logic              pop_i,
  output logic              head_valid_o,
  output item_t             head_o
);

  localparam int unsigned PtrW = $clog2(QueueDepth);
  localparam int unsigned CntW = $clog2(QueueDepth + 1);
  localparam logic [PtrW-1:0] LastPtr = PtrW'(QueueDepth - 1);
  localparam logic [CntW-1:0] FullCnt = CntW'(QueueDepth);

  function automatic angle_t classify(input logic [AngleW-1:0] ang);
    logic signed [FoldW-1:0] ph;
    logic signed [FoldW-1:0] folded;
    angle_t                  res;
    ph        = {ang[AngleW-1], ang, 17'b0};
    folded    = ph;
    res.neg   = 1'b0;
    if (ph > PhaseHalfPi) begin
      folded  = ph - PhasePi;
      res.neg = 1'b1;
    end else if (ph < -PhaseHalfPi) begin
      folded  = ph + PhasePi;
      res.neg = 1'b1;
    end
    res.phase = folded[PhaseW-1:0];
    return res;
  endfunction

  item_t            mem_q [QueueDepth];
  item_t            item_in;
  logic [PtrW-1:0]  wr_ptr_q, wr_ptr_d, rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0]  cnt_q, cnt_d;
  logic             push;

  assign in_ready_o   = (cnt_q != FullCnt);
  assign push         = in_valid_i && in_ready_o;
  assign head_valid_o = (cnt_q != '0);
  assign head_o       = mem_q[rd_ptr_q];

  always_comb begin
    item_in.alpha = classify(angle_alpha_i);
    item_in.beta  = classify(angle_beta_i);
    item_in.gamma = classify(angle_gamma_i);
  end

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (push) begin
      wr_ptr_d = (wr_ptr_q == LastPtr) ? '0 : wr_ptr_q + 1'b1;
    end
    if (pop_i) begin
      rd_ptr_d = (rd_ptr_q == LastPtr) ? '0 : rd_ptr_q + 1'b1;
    end
    if (push && !pop_i) begin
      cnt_d = cnt_q + 1'b1;
    end else if (!push && pop_i) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wr_ptr_q] <= item_in;
    end
  end

  assert property (@(posedge clk_i) disable iff (!rst_ni) cnt_q <= FullCnt)
    else $error("Queue occupancy exceeds its depth.");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop_i && !push |=> cnt_q == $past(cnt_q) - 1'b1)
    else $error("Queue occupancy did not drop after a lone read.");

endmodule

`default_nettype wire

// ----- rtl/rfe_cordic.sv -----
// Pipelined rotation-mode CORDIC giving the sine and cosine of one folded angle.
`default_nettype none

module rfe_cordic import rfe_pkg::*; (
  input  logic                    clk_i,
  input  logic                    en_i,
  input  angle_t                  angle_i,
  output logic signed [TrigW-1:0] sin_o,
  output logic signed [TrigW-1:0] cos_o
);

  logic signed [PhaseW-1:0] x_q [CordicSteps];
  logic signed [PhaseW-1:0] y_q [CordicSteps];
  logic signed [PhaseW-1:0] z_q [CordicSteps];
  logic signed [PhaseW-1:0] x_d [CordicSteps];
  logic signed [PhaseW-1:0] y_d [CordicSteps];
  logic signed [PhaseW-1:0] z_d [CordicSteps];
  logic [CordicSteps-1:0]   neg_q, neg_d;
  logic signed [TrigW-1:0]  sin_q, sin_d, cos_q, cos_d;

  always_comb begin
    logic signed [PhaseW-1:0] xi, yi, zi;
    for (int i = 0; i < CordicSteps; i++) begin
      if (i == 0) begin
        xi       = CordicX0;
        yi       = '0;
        zi       = angle_i.phase;
        neg_d[i] = angle_i.neg;
      end else begin
        xi       = x_q[i-1];
        yi       = y_q[i-1];
        zi       = z_q[i-1];
        neg_d[i] = neg_q[i-1];
      end
      if (!zi[PhaseW-1]) begin
        x_d[i] = xi - (yi >>> i);
        y_d[i] = yi + (xi >>> i);
        z_d[i] = zi - AtanTab[i];
      end else begin
        x_d[i] = xi + (yi >>> i);
        y_d[i] = yi - (xi >>> i);
        z_d[i] = zi + AtanTab[i];
      end
    end
  end

  always_comb begin
    logic signed [PhaseW-1:0] xr, yr;
    xr = (x_q[CordicSteps-1] + 32'sd512) >>> 10;
    yr = (y_q[CordicSteps-1] + 32'sd512) >>> 10;
    cos_d = xr[TrigW-1:0];
    sin_d = yr[TrigW-1:0];
    if (neg_q[CordicSteps-1]) begin
      cos_d = -xr[TrigW-1:0];
      sin_d = -yr[TrigW-1:0];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      x_q   <= x_d;
      y_q   <= y_d;
      z_q   <= z_d;
      neg_q <= neg_d;
      sin_q <= sin_d;
      cos_q <= cos_d;
    end
  end

  assign sin_o = sin_q;
  assign cos_o = cos_q;

endmodule

`default_nettype wire

// ----- rtl/rfe_matrix.sv -----
// Back end products: forms the nine matrix entries from the sines and cosines.
`default_nettype none

module rfe_matrix import rfe_pkg::*; (
  input  logic    clk_i,
  input  logic    en_i,
  input  trig_t   trig_i,
  output matrix_t elem_o
);

  localparam int unsigned HiW  = ProdW - 21;
  localparam int unsigned HcW  = HiW + TrigW;
  localparam int unsigned SumW = 64;

  function automatic logic signed [SumW-1:0] triple(input logic signed [HcW-1:0] h,
                                                     input logic signed [ProdW-1:0] l);
    return (SumW'(h) <<< 21) + SumW'(l);
  endfunction

  function automatic logic signed [SumW-1:0] pair(input logic signed [ProdW-1:0] p);
    return SumW'(p) <<< 20;
  endfunction

  function automatic logic [ElemW-1:0] rnd_sat(input logic signed [SumW-1:0] v,
                                               input int unsigned sh);
    logic signed [SumW-1:0] r;
    r = (v + (64'sd1 <<< (sh - 1))) >>> sh;
    if (r > 64'sd16384) begin
      r = 64'sd16384;
    end else if (r < -64'sd16384) begin
      r = -64'sd16384;
    end
    return r[ElemW-1:0];
  endfunction

  // First stage: two-factor products.
  logic signed [ProdW-1:0] cbcg_q, cbsg_q, sacb_q, cacb_q;
  logic signed [ProdW-1:0] casg_q, sasg_q, cacg_q, sacg_q, sasb_q, casb_q;
  logic signed [TrigW-1:0] sb_a_q, sg_a_q, cg_a_q;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      cbcg_q <= trig_i.cb * trig_i.cg;
      cbsg_q <= trig_i.cb * trig_i.sg;
      sacb_q <= trig_i.sa * trig_i.cb;
      cacb_q <= trig_i.ca * trig_i.cb;
      casg_q <= trig_i.ca * trig_i.sg;
      sasg_q <= trig_i.sa * trig_i.sg;
      cacg_q <= trig_i.ca * trig_i.cg;
      sacg_q <= trig_i.sa * trig_i.cg;
      sasb_q <= trig_i.sa * trig_i.sb;
      casb_q <= trig_i.ca * trig_i.sb;
      sb_a_q <= trig_i.sb;
      sg_a_q <= trig_i.sg;
      cg_a_q <= trig_i.cg;
    end
  end

  // Second stage: three-factor products, split into high and low partial products.
  logic signed [HiW-1:0]   sasb_hi, casb_hi;
  logic signed [TrigW-1:0] sasb_lo, casb_lo;

  assign sasb_hi = sasb_q[ProdW-1:21];
  assign casb_hi = casb_q[ProdW-1:21];
  assign sasb_lo = $signed({1'b0, sasb_q[20:0]});
  assign casb_lo = $signed({1'b0, casb_q[20:0]});

  logic signed [HcW-1:0]   t1h_q, t2h_q, t3h_q, t4h_q;
  logic signed [ProdW-1:0] t1l_q, t2l_q, t3l_q, t4l_q;
  logic signed [ProdW-1:0] cbcg_b_q, cbsg_b_q, sacb_b_q, cacb_b_q;
  logic signed [ProdW-1:0] casg_b_q, sasg_b_q, cacg_b_q, sacg_b_q;
  logic signed [TrigW-1:0] sb_b_q;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      t1h_q    <= sasb_hi * cg_a_q;
      t1l_q    <= sasb_lo * cg_a_q;
      t2h_q    <= casb_hi * cg_a_q;
      t2l_q    <= casb_lo * cg_a_q;
      t3h_q    <= sasb_hi * sg_a_q;
      t3l_q    <= sasb_lo * sg_a_q;
      t4h_q    <= casb_hi * sg_a_q;
      t4l_q    <= casb_lo * sg_a_q;
      cbcg_b_q <= cbcg_q;
      cbsg_b_q <= cbsg_q;
      sacb_b_q <= sacb_q;
      cacb_b_q <= cacb_q;
      casg_b_q <= casg_q;
      sasg_b_q <= sasg_q;
      cacg_b_q <= cacg_q;
      sacg_b_q <= sacg_q;
      sb_b_q   <= sb_a_q;
    end
  end

  // Third stage: sums, rounding to Q1.14 and saturation.
  matrix_t elem_q, elem_d;

  always_comb begin
    elem_d.r1c1 = rnd_sat(SumW'(cbcg_b_q), 26);
    elem_d.r2c1 = rnd_sat(pair(casg_b_q) + triple(t1h_q, t1l_q), 46);
    elem_d.r3c1 = rnd_sat(pair(sasg_b_q) - triple(t2h_q, t2l_q), 46);
    elem_d.r1c2 = rnd_sat(-SumW'(cbsg_b_q), 26);
    elem_d.r2c2 = rnd_sat(pair(cacg_b_q) - triple(t3h_q, t3l_q), 46);
    elem_d.r3c2 = rnd_sat(pair(sacg_b_q) + triple(t4h_q, t4l_q), 46);
    elem_d.r1c3 = rnd_sat(SumW'(sb_b_q), 6);
    elem_d.r2c3 = rnd_sat(-SumW'(sacb_b_q), 26);
    elem_d.r3c3 = rnd_sat(SumW'(cacb_b_q), 26);
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      elem_q <= elem_d;
    end
  end

  assign elem_o = elem_q;

endmodule

`default_nettype wire

// ----- rtl/rotation_from_euler_angles.sv -----
// Rotation matrix Rx(alpha)*Ry(beta)*Rz(gamma) from three Euler angles.
// Path from input transaction to output: the transaction enters the queue; the queue read shares its cycle
// with the first CORDIC step, then come 15 further steps, one rounding stage and 3 matrix stages
// (two multiply stages and one summing stage).
// Throughput: one transaction per cycle; the pipeline advances whenever its output is free.
// Reset clears the queue pointers and the pipeline valid flags; data registers are not reset.
`default_nettype none

module rotation_from_euler_angles import rfe_pkg::*; #(
  parameter int unsigned QueueDepth = 4
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  logic [AngleW-1:0] angle_alpha_i,
  input  logic [AngleW-1:0] angle_beta_i,
  input  logic [AngleW-1:0] angle_gamma_i,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output logic [ElemW-1:0]  elem_r1c1_o,
  output logic [ElemW-1:0]  elem_r2c1_o,
  output logic [ElemW-1:0]  elem_r3c1_o,
  output logic [ElemW-1:0]  elem_r1c2_o,
  output logic [ElemW-1:0]  elem_r2c2_o,
  output logic [ElemW-1:0]  elem_r3c2_o,
  output logic [ElemW-1:0]  elem_r1c3_o,
  output logic [ElemW-1:0]  elem_r2c3_o,
  output logic [ElemW-1:0]  elem_r3c3_o
);

  logic                  head_valid, en, pop;
  item_t                 head;
  trig_t                 trig;
  matrix_t               elem;
  logic [PipeStages-1:0] vld_q, vld_d;

  rfe_front #(
    .QueueDepth(QueueDepth)
  ) u_front (
    .clk_i,
    .rst_ni,
    .in_valid_i,
    .in_ready_o,
    .angle_alpha_i,
    .angle_beta_i,
    .angle_gamma_i,
    .pop_i       (pop),
    .head_valid_o(head_valid),
    .head_o      (head)
  );

  assign en  = !vld_q[PipeStages-1] || out_ready_i;
  assign pop = en && head_valid;

  rfe_cordic u_cordic_alpha (
    .clk_i,
    .en_i   (en),
    .angle_i(head.alpha),
    .sin_o  (trig.sa),
    .cos_o  (trig.ca)
  );

  rfe_cordic u_cordic_beta (
    .clk_i,
    .en_i   (en),
    .angle_i(head.beta),
    .sin_o  (trig.sb),
    .cos_o  (trig.cb)
  );

  rfe_cordic u_cordic_gamma (
    .clk_i,
    .en_i   (en),
    .angle_i(head.gamma),
    .sin_o  (trig.sg),
    .cos_o  (trig.cg)
  );

  rfe_matrix u_matrix (
    .clk_i,
    .en_i  (en),
    .trig_i(trig),
    .elem_o(elem)
  );

  assign vld_d = {vld_q[PipeStages-2:0], pop};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en) begin
      vld_q <= vld_d;
    end
  end

  assign out_valid_o = vld_q[PipeStages-1];
  assign elem_r1c1_o = elem.r1c1;
  assign elem_r2c1_o = elem.r2c1;
  assign elem_r3c1_o = elem.r3c1;
  assign elem_r1c2_o = elem.r1c2;
  assign elem_r2c2_o = elem.r2c2;
  assign elem_r3c2_o = elem.r3c2;
  assign elem_r1c3_o = elem.r1c3;
  assign elem_r2c3_o = elem.r2c3;
  assign elem_r3c3_o = elem.r3c3;

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> $stable(vld_q))
    else $error("Pipeline moved while its output was stalled.");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_ready_o |-> head_valid)
    else $error("Queue refuses transactions yet shows no head entry.");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> ($signed(elem_r3c3_o) <= 16'sd16384) &&
                    ($signed(elem_r3c3_o) >= -16'sd16384))
    else $error("Matrix entry outside the saturation range.");

endmodule

`default_nettype wire

// ----- test/rotation_from_euler_angles_tb.sv -----
// Self-checking testbench for the Euler-angle rotation matrix block.
`timescale 1ns / 1ps

module rotation_from_euler_angles_tb;
  import rfe_pkg::*;

  localparam int     NumRandom   = 2000;
  localparam int     NumDirected = 20;
  localparam int     DrainCycles = 40;
  localparam int     HoldCycles  = 300;
  localparam longint TrigOne     = 64'sd1048576;
  localparam longint LimitNs     = 64'd2000000;

  class matrix_book;
    matrix_t pending[$];
    int      failures;
    string   elem_names[9] = '{"elem_r1c1", "elem_r2c1", "elem_r3c1",
                               "elem_r1c2", "elem_r2c2", "elem_r3c2",
                               "elem_r1c3", "elem_r2c3", "elem_r3c3"};

    function void sin_cos(input logic [AngleW-1:0] angle, output longint sn,
                          output longint cs);
      longint z;
      longint x;
      longint y;
      longint dx;
      longint dy;
      bit     flip;
      z = longint'($signed(angle)) * 131072;
      x = longint'(CordicX0);
      y = 0;
      flip = 1'b0;
      if (z > longint'(PhaseHalfPi)) begin
        z -= longint'(PhasePi);
        flip = 1'b1;
      end else if (z < -longint'(PhaseHalfPi)) begin
        z += longint'(PhasePi);
        flip = 1'b1;
      end
      for (int i = 0; i < CordicSteps; i++) begin
        dx = y >>> i;
        dy = x >>> i;
        if (z >= 0) begin
          x -= dx;
          y += dy;
          z -= longint'(AtanTab[i]);
        end else begin
          x += dx;
          y -= dy;
          z += longint'(AtanTab[i]);
        end
      end
      x = (x + 512) >>> 10;
      y = (y + 512) >>> 10;
      if (flip) begin
        x = -x;
        y = -y;
      end
      sn = y;
      cs = x;
    endfunction

    function logic [ElemW-1:0] to_q14(input longint v, input int shift);
      longint r;
      r = (v + (longint'(1) << (shift - 1))) >>> shift;
      if (r > 16384) r = 16384;
      if (r < -16384) r = -16384;
      return r[ElemW-1:0];
    endfunction

    function matrix_t rotation_of(input logic [AngleW-1:0] a, input logic [AngleW-1:0] b,
                                  input logic [AngleW-1:0] g);
      matrix_t m;
      longint  sa, ca, sb, cb, sg, cg;
      sin_cos(a, sa, ca);
      sin_cos(b, sb, cb);
      sin_cos(g, sg, cg);
      m.r1c1 = to_q14(cb * cg, 26);
      m.r2c1 = to_q14(ca * sg * TrigOne + sa * sb * cg, 46);
      m.r3c1 = to_q14(sa * sg * TrigOne - ca * sb * cg, 46);
      m.r1c2 = to_q14(-(cb * sg), 26);
      m.r2c2 = to_q14(ca * cg * TrigOne - sa * sb * sg, 46);
      m.r3c2 = to_q14(sa * cg * TrigOne + ca * sb * sg, 46);
      m.r1c3 = to_q14(sb, 6);
      m.r2c3 = to_q14(-(sa * cb), 26);
      m.r3c3 = to_q14(ca * cb, 26);
      return m;
    endfunction

    function void note_angles(input logic [AngleW-1:0] a, input logic [AngleW-1:0] b,
                              input logic [AngleW-1:0] g);
      pending.push_back(rotation_of(a, b, g));
    endfunction

    function void check_matrix(input matrix_t got);
      matrix_t          want;
      logic [ElemW-1:0] exp_e;
      logic [ElemW-1:0] got_e;
      if (pending.size() == 0) begin
        $error("Output transaction arrived with no matrix outstanding.");
        failures++;
        return;
      end
      want = pending.pop_front();
      for (int k = 0; k < 9; k++) begin
        exp_e = want[(8 - k) * ElemW +: ElemW];
        got_e = got[(8 - k) * ElemW +: ElemW];
        if (exp_e !== got_e) begin
          $error("%s: expected %0d, got %0d", elem_names[k], $signed(exp_e),
                 $signed(got_e));
          failures++;
        end
      end
    endfunction

    function int pending_count();
      return pending.size();
    endfunction
  endclass

  logic              clk_i;
  logic              rst_ni;
  logic              in_valid_i;
  logic              in_ready_o;
  logic [AngleW-1:0] angle_alpha_i;
  logic [AngleW-1:0] angle_beta_i;
  logic [AngleW-1:0] angle_gamma_i;
  logic              out_valid_o;
  logic              out_ready_i;
  logic [ElemW-1:0]  elem_r1c1_o;
  logic [ElemW-1:0]  elem_r2c1_o;
  logic [ElemW-1:0]  elem_r3c1_o;
  logic [ElemW-1:0]  elem_r1c2_o;
  logic [ElemW-1:0]  elem_r2c2_o;
  logic [ElemW-1:0]  elem_r3c2_o;
  logic [ElemW-1:0]  elem_r1c3_o;
  logic [ElemW-1:0]  elem_r2c3_o;
  logic [ElemW-1:0]  elem_r3c3_o;

  matrix_book book;

  shortint directed_angles [NumDirected][3] = '{
    '{0, 0, 0},
    '{32767, 32767, 32767},
    '{-32768, -32768, -32768},
    '{25736, 0, 0},
    '{0, 25736, 0},
    '{0, 0, 25736},
    '{-25736, -25736, -25736},
    '{12867, 12867, 12867},
    '{12868, 12868, 12868},
    '{-12867, -12867, -12867},
    '{-12868, -12868, -12868},
    '{12868, -12868, 0},
    '{0, 12868, 0},
    '{0, -12868, 0},
    '{21845, -21846, 21845},
    '{-21846, 21845, -21846},
    '{1, -1, 1},
    '{6434, 6434, 6434},
    '{-32768, 32767, 0},
    '{8579, -17157, 25736}
  };

  rotation_from_euler_angles u_dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_ready_o   (in_ready_o),
    .angle_alpha_i(angle_alpha_i),
    .angle_beta_i (angle_beta_i),
    .angle_gamma_i(angle_gamma_i),
    .out_valid_o  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .elem_r1c1_o  (elem_r1c1_o),
    .elem_r2c1_o  (elem_r2c1_o),
    .elem_r3c1_o  (elem_r3c1_o),
    .elem_r1c2_o  (elem_r1c2_o),
    .elem_r2c2_o  (elem_r2c2_o),
    .elem_r3c2_o  (elem_r3c2_o),
    .elem_r1c3_o  (elem_r1c3_o),
    .elem_r2c3_o  (elem_r2c3_o),
    .elem_r3c3_o  (elem_r3c3_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #4 clk_i = ~clk_i;
  end

  initial begin
    #(LimitNs);
    $display("** rotation_from_euler_angles: FAILED **");
    $finish;
  end

  // Every transaction on either side is observed at the rising edge.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (in_valid_i && in_ready_o) begin
        book.note_angles(angle_alpha_i, angle_beta_i, angle_gamma_i);
      end
      if (out_valid_o && out_ready_i) begin
        book.check_matrix({elem_r1c1_o, elem_r2c1_o, elem_r3c1_o,
                           elem_r1c2_o, elem_r2c2_o, elem_r3c2_o,
                           elem_r1c3_o, elem_r2c3_o, elem_r3c3_o});
      end
    end
  end

  function automatic logic [AngleW-1:0] random_angle();
    int kind;
    int v;
    kind = $urandom_range(0, 9);
    if (kind < 5) begin
      v = $urandom_range(0, 65535);
    end else if (kind < 8) begin
      v = int'($urandom_range(0, 51472)) - 25736;
    end else if (kind == 8) begin
      v = (int'($urandom_range(0, 4)) - 2) * 12868 + int'($urandom_range(0, 8)) - 4;
    end else begin
      v = int'($urandom_range(0, 64)) - 32;
    end
    return v[AngleW-1:0];
  endfunction

  // Called at a falling edge; returns at the falling edge after the transaction.
  task automatic send_angles(input logic [AngleW-1:0] a, input logic [AngleW-1:0] b,
                             input logic [AngleW-1:0] g);
    in_valid_i    <= 1'b1;
    angle_alpha_i <= a;
    angle_beta_i  <= b;
    angle_gamma_i <= g;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    @(negedge clk_i);
  endtask

  task automatic pause_sender(input int cycles);
    in_valid_i    <= 1'b0;
    angle_alpha_i <= random_angle();
    angle_beta_i  <= random_angle();
    angle_gamma_i <= random_angle();
    repeat (cycles) @(negedge clk_i);
  endtask

  // The receiver runs its own pattern, with one long hold-off to fill the pipeline.
  initial begin : receiver
    int  kind;
    int  len;
    int  cycle_no;
    bit  held;
    out_ready_i = 1'b0;
    cycle_no = 0;
    held = 1'b0;
    wait (rst_ni === 1'b1);
    forever begin
      if (!held && cycle_no >= 600) begin
        held = 1'b1;
        for (int n = 0; n < HoldCycles; n++) begin
          @(negedge clk_i);
          out_ready_i <= 1'b0;
          cycle_no++;
        end
      end
      kind = $urandom_range(0, 3);
      len  = $urandom_range(20, 200);
      for (int n = 0; n < len; n++) begin
        @(negedge clk_i);
        case (kind)
          0: begin
            out_ready_i <= 1'b1;
          end
          1: begin
            out_ready_i <= 1'($urandom_range(0, 1));
          end
          2: begin
            out_ready_i <= ($urandom_range(0, 7) != 0);
          end
          default: begin
            out_ready_i <= ((n % 3) != 0);
          end
        endcase
        cycle_no++;
      end
    end
  end

  initial begin
    int burst;
    int gap;
    int sent;
    book          = new();
    rst_ni        = 1'b0;
    in_valid_i    = 1'b0;
    angle_alpha_i = '0;
    angle_beta_i  = '0;
    angle_gamma_i = '0;
    repeat (10) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    for (int k = 0; k < NumDirected; k++) begin
      send_angles(directed_angles[k][0], directed_angles[k][1], directed_angles[k][2]);
    end

    sent = 0;
    while (sent < NumRandom) begin
      burst = $urandom_range(1, 40);
      for (int n = 0; n < burst && sent < NumRandom; n++) begin
        send_angles(random_angle(), random_angle(), random_angle());
        sent++;
      end
      gap = ($urandom_range(0, 4) == 0) ? 0 : $urandom_range(1, 6);
      if (gap > 0) begin
        pause_sender(gap);
      end
    end
    in_valid_i <= 1'b0;

    while (book.pending_count() > 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);

    if (book.failures == 0) begin
      $display("** rotation_from_euler_angles: PASSED **");
    end else begin
      $display("** rotation_from_euler_angles: FAILED **");
    end
    $finish;
  end

endmodule

// ----- filelist.f -----
rtl/rfe_pkg.sv
rtl/rfe_front.sv
rtl/rfe_cordic.sv
rtl/rfe_matrix.sv
rtl/rotation_from_euler_angles.sv
test/rotation_from_euler_angles_tb.sv
